/* rtl/wlac_pkg.sv */
// ----------------------------------------------------------------------------
// wlac_pkg
// shared types and constants of the water level averager and classifier
// ----------------------------------------------------------------------------
package wlac_pkg;

  localparam int CAL_W     = 12;  // calibration reading width
  localparam int PCT_W     = 7;   // percentage width
  localparam int CLASS_W   = 2;   // level class width
  localparam int CFG_IDX_W = 3;   // register index width
  localparam int CFG_DAT_W = 12;  // register write data width
  localparam int SPAN_W    = CAL_W + 1;        // signed difference of two readings
  localparam int PROD_W    = CAL_W + 6;        // |difference| * 50

  localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [5:0]       PCT_SEG  = 6'd50;  // percent covered by one segment

  localparam logic [CAL_W-1:0] EMPTY_RST     = 12'd0;
  localparam logic [CAL_W-1:0] HALF_RST      = 12'd2048;
  localparam logic [CAL_W-1:0] FULL_RST      = 12'd4095;
  localparam logic [PCT_W-1:0] LOW_THR_RST   = 7'd50;
  localparam logic [PCT_W-1:0] FULL_THR_RST  = 7'd80;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_POINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_POINT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POINT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_THRESHOLD = 3'd4;

  // level classes
  localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MED  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_FULL = 2'd2;

  typedef struct packed {
    logic [CAL_W-1:0] empty_point;
    logic [CAL_W-1:0] half_point;
    logic [CAL_W-1:0] full_point;
    logic [PCT_W-1:0] low_threshold;
    logic [PCT_W-1:0] full_threshold;
  } cal_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SCALE,
    ST_PCT,
    ST_DONE
  } back_state_t;

endpackage

/* rtl/water_level_averager_classifier_top.sv */
// ----------------------------------------------------------------------------
// water_level_averager_classifier_top
// boxcar average of converter samples with two-segment level calibration
// ----------------------------------------------------------------------------
// Samples enter through a queue-style port (push/full) and are summed in
// groups of SAMPLES; one result per group leaves through a second queue-style
// port (empty/pop) carrying the truncated mean, the calibrated percentage
// (0..100) and a low/medium/full class. The front accumulator takes one sample
// every cycle and only holds off (full) on a group's last sample while the
// two-entry group queue is full. The back end works one group at a time and
// takes these steps in order: it reads the group sum and takes the mean by
// reciprocal multiplication, clamps, starts the one-bit-per-cycle segment
// divider, waits for it, picks up and saturates the quotient and loads the
// result register, which waits while an unread result sits there; a chosen
// segment of zero span skips the divider and the quotient. Registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high and indexes past the last register are ignored. Write registers only
// while no group is in flight.
// ----------------------------------------------------------------------------
module water_level_averager_classifier_top #(
  parameter int SAMPLES  = 10,
  parameter int ADC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample side
  input  logic                           push,
  output logic                           full,
  input  logic [wlac_pkg::CAL_W-1:0]     adc_sample,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic [wlac_pkg::CAL_W-1:0]     mean_reading,
  output logic [wlac_pkg::PCT_W-1:0]     level_percent,
  output logic [wlac_pkg::CLASS_W-1:0]   level_class,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wlac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wlac_pkg::CFG_DAT_W-1:0] cfg_data
);

  // worst-case group sum sets the accumulator width
  localparam int SUM_MAX = SAMPLES * ((1 << ADC_BITS) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  wlac_pkg::cal_t   cal;
  logic             q_wr;
  logic [SUM_W-1:0] q_wdata;
  logic             q_full;
  logic             q_rd;
  logic [SUM_W-1:0] q_rdata;
  logic             q_empty;
  logic             cfg_xfer;

  // register file: every write transfer to a mapped index lands at once
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.empty_point    <= wlac_pkg::EMPTY_RST;
      cal.half_point     <= wlac_pkg::HALF_RST;
      cal.full_point     <= wlac_pkg::FULL_RST;
      cal.low_threshold  <= wlac_pkg::LOW_THR_RST;
      cal.full_threshold <= wlac_pkg::FULL_THR_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        wlac_pkg::REG_EMPTY_POINT:    cal.empty_point    <= wlac_pkg::CAL_W'(cfg_data);
        wlac_pkg::REG_HALF_POINT:     cal.half_point     <= wlac_pkg::CAL_W'(cfg_data);
        wlac_pkg::REG_FULL_POINT:     cal.full_point     <= wlac_pkg::CAL_W'(cfg_data);
        wlac_pkg::REG_LOW_THRESHOLD:  cal.low_threshold  <= wlac_pkg::PCT_W'(cfg_data);
        wlac_pkg::REG_FULL_THRESHOLD: cal.full_threshold <= wlac_pkg::PCT_W'(cfg_data);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: accumulate one group
  wlac_front #(
    .SAMPLES  (SAMPLES),
    .ADC_BITS (ADC_BITS),
    .SUM_W    (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .adc_sample (adc_sample),
    .full       (full),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_data     (q_wdata)
  );

  // group sums waiting for the back end
  wlac_fifo #(
    .W     (SUM_W),
    .DEPTH (2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // back: mean, calibration, class, result register
  wlac_back #(
    .SAMPLES  (SAMPLES),
    .ADC_BITS (ADC_BITS),
    .SUM_W    (SUM_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cal           (cal),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .mean_reading  (mean_reading),
    .level_percent (level_percent),
    .level_class   (level_class)
  );

endmodule

/* rtl/wlac_fifo.sv */
// ----------------------------------------------------------------------------
// wlac_fifo
// short flip-flop queue between the accumulator and the calibration back end
// ----------------------------------------------------------------------------
module wlac_fifo #(
  parameter int W     = 20,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/wlac_div.sv */
// ----------------------------------------------------------------------------
// wlac_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wlac_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsor;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, acc[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dsor});
  assign quo   = acc;

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= num;
      rem  <= '0;
      dsor <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, dsor}) : DEN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/wlac_front.sv */
// ----------------------------------------------------------------------------
// wlac_front
// sample accumulator: sums one group of samples and queues the group sum
// ----------------------------------------------------------------------------
module wlac_front #(
  parameter int SAMPLES  = 10,
  parameter int ADC_BITS = 12,
  parameter int SUM_W    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [wlac_pkg::CAL_W-1:0] adc_sample,
  output logic                       full,
  input  logic                       q_full,
  output logic                       q_wr,
  output logic [SUM_W-1:0]           q_data
);

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    cnt;
  logic [ADC_BITS-1:0] sample_m;
  logic [SUM_W-1:0]    sum_add;
  logic                last;
  logic                accept;

  assign sample_m = ADC_BITS'(adc_sample);
  assign sum_add  = sum + SUM_W'(sample_m);
  assign last     = (cnt == CNT_W'(SAMPLES - 1));
  // only the group-closing sample needs room in the queue
  assign full     = q_full && last;
  assign accept   = push && !full;
  assign q_wr     = accept && last;
  assign q_data   = sum_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      cnt <= '0;
    end else if (accept) begin
      if (last) begin
        sum <= '0;
        cnt <= '0;
      end else begin
        sum <= sum_add;
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

/* rtl/wlac_back.sv */
// ----------------------------------------------------------------------------
// wlac_back
// mean, clamp, two-segment percentage map, classification and result register
// ----------------------------------------------------------------------------
module wlac_back #(
  parameter int SAMPLES  = 10,
  parameter int ADC_BITS = 12,
  parameter int SUM_W    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wlac_pkg::cal_t               cal,
  input  logic                         q_empty,
  input  logic [SUM_W-1:0]             q_data,
  output logic                         q_rd,
  output logic                         empty,
  input  logic                         pop,
  output logic [wlac_pkg::CAL_W-1:0]   mean_reading,
  output logic [wlac_pkg::PCT_W-1:0]   level_percent,
  output logic [wlac_pkg::CLASS_W-1:0] level_class
);

  localparam int CAL_W  = wlac_pkg::CAL_W;
  localparam int PCT_W  = wlac_pkg::PCT_W;
  localparam int SPAN_W = wlac_pkg::SPAN_W;
  localparam int PROD_W = wlac_pkg::PROD_W;
  localparam int DIV_NW = PROD_W;
  localparam int SW     = DIV_NW + 2;
  localparam int CMP_W  = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;
  localparam logic signed [SW-1:0] PCT_MAX_S = SW'(wlac_pkg::PCT_FULL);

  // mean by reciprocal multiplication, exact for every SUM_W-bit group sum
  localparam int RCP_SH = SUM_W + $clog2(SAMPLES);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PRD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SH) + 64'(SAMPLES - 1)) / 64'(SAMPLES));

  wlac_pkg::back_state_t state, state_next;

  logic [ADC_BITS-1:0] mean, mean_next;
  logic [CAL_W-1:0]    lvl, lvl_next;
  logic                upper, upper_next;
  logic                neg, neg_next;
  logic [PCT_W-1:0]    pct, pct_next;
  logic                res_valid;
  logic                res_load;

  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [CAL_W-1:0]    div_den;
  logic                div_done;
  logic [DIV_NW-1:0]   div_quo;

  logic [PRD_W-1:0]         sum_prod;
  logic [CMP_W-1:0]         mean_c;
  logic [CAL_W-1:0]         seg_a;
  logic [CAL_W-1:0]         seg_b;
  logic [PCT_W-1:0]         seg_base;
  logic signed [SPAN_W-1:0] diff;
  logic signed [SPAN_W-1:0] span;
  logic [CAL_W-1:0]         diff_mag;
  logic [CAL_W-1:0]         span_mag;
  logic [PROD_W-1:0]        scaled;
  logic signed [SW-1:0]     q_s;
  logic signed [SW-1:0]     total;
  logic [wlac_pkg::CLASS_W-1:0] cls;

  wlac_div #(
    .NUM_W (DIV_NW),
    .DEN_W (CAL_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign sum_prod = PRD_W'(q_data) * PRD_W'(RCP_MUL);

  // segment end points
  assign seg_a    = upper ? cal.half_point : cal.empty_point;
  assign seg_b    = upper ? cal.full_point : cal.half_point;
  assign seg_base = upper ? wlac_pkg::PCT_HALF : wlac_pkg::PCT_ZERO;
  assign diff     = $signed({1'b0, lvl}) - $signed({1'b0, seg_a});
  assign span     = $signed({1'b0, seg_b}) - $signed({1'b0, seg_a});
  assign diff_mag = diff[SPAN_W-1] ? CAL_W'(-diff) : CAL_W'(diff);
  assign span_mag = span[SPAN_W-1] ? CAL_W'(-span) : CAL_W'(span);
  assign scaled   = PROD_W'(diff_mag) * PROD_W'(wlac_pkg::PCT_SEG);
  assign mean_c   = CMP_W'(mean);

  // signed quotient, truncated toward zero, plus segment start
  assign q_s   = neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign total = q_s + $signed(SW'(seg_base));

  always_comb begin
    if (pct < cal.low_threshold) begin
      cls = wlac_pkg::CLASS_LOW;
    end else if (pct < cal.full_threshold) begin
      cls = wlac_pkg::CLASS_MED;
    end else begin
      cls = wlac_pkg::CLASS_FULL;
    end
  end

  always_comb begin
    state_next = state;
    mean_next  = mean;
    lvl_next   = lvl;
    upper_next = upper;
    neg_next   = neg;
    pct_next   = pct;
    q_rd       = 1'b0;
    div_start  = 1'b0;
    div_num    = DIV_NW'(scaled);
    div_den    = span_mag;
    res_load   = 1'b0;
    unique case (state)
      wlac_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_rd       = 1'b1;
          mean_next  = ADC_BITS'(sum_prod >> RCP_SH);
          state_next = wlac_pkg::ST_CLAMP;
        end
      end
      wlac_pkg::ST_CLAMP: begin
        // empty point is tested first
        if (mean_c < CMP_W'(cal.empty_point)) begin
          lvl_next = cal.empty_point;
        end else if (mean_c > CMP_W'(cal.full_point)) begin
          lvl_next = cal.full_point;
        end else begin
          lvl_next = CAL_W'(mean_c);
        end
        upper_next = (lvl_next > cal.half_point);
        state_next = wlac_pkg::ST_SCALE;
      end
      wlac_pkg::ST_SCALE: begin
        if (span == '0) begin
          pct_next   = seg_base;
          state_next = wlac_pkg::ST_DONE;
        end else begin
          div_start  = 1'b1;
          neg_next   = diff[SPAN_W-1] ^ span[SPAN_W-1];
          state_next = wlac_pkg::ST_PCT;
        end
      end
      wlac_pkg::ST_PCT: begin
        if (div_done) begin
          if (total < 0) begin
            pct_next = wlac_pkg::PCT_ZERO;
          end else if (total > PCT_MAX_S) begin
            pct_next = wlac_pkg::PCT_FULL;
          end else begin
            pct_next = PCT_W'(total);
          end
          state_next = wlac_pkg::ST_DONE;
        end
      end
      wlac_pkg::ST_DONE: begin
        if (!res_valid || pop) begin
          res_load   = 1'b1;
          state_next = wlac_pkg::ST_IDLE;
        end
      end
      default: state_next = wlac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wlac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mean  <= mean_next;
    lvl   <= lvl_next;
    upper <= upper_next;
    neg   <= neg_next;
    pct   <= pct_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      mean_reading  <= CAL_W'(mean);
      level_percent <= pct;
      level_class   <= cls;
    end
  end

  assign empty = !res_valid;

endmodule

/* rtl/wlac_checker.sv */
// ----------------------------------------------------------------------------
// wlac_checker
// port-level checks of the averager, bound to the top level
// ----------------------------------------------------------------------------
module wlac_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic [wlac_pkg::CAL_W-1:0]   mean_reading,
  input logic [wlac_pkg::PCT_W-1:0]   level_percent,
  input logic [wlac_pkg::CLASS_W-1:0] level_class
);

  // a waiting result stays until its transfer
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result dropped before transfer");

  // a waiting result does not change
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(mean_reading) && $stable(level_percent) &&
                       $stable(level_class))
    else $error("waiting result changed");

  // saturation keeps the percentage in range
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> level_percent <= wlac_pkg::PCT_FULL)
    else $error("percentage above full scale");

  // class follows the percentage ends: zero percent can never be full unless
  // both thresholds are zero, so only check the class code range here
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> level_class == wlac_pkg::CLASS_LOW || level_class == wlac_pkg::CLASS_MED ||
               level_class == wlac_pkg::CLASS_FULL)
    else $error("bad level class");

endmodule

bind water_level_averager_classifier_top wlac_checker u_wlac_checker (.*);

/* bench/water_level_averager_classifier_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_level_averager_classifier_top_tb
// self-checking bench for the sample averager and level classifier
// ----------------------------------------------------------------------------
// A queue-fed driver pushes converter samples and a monitor pops results
// under random idling on both sides. Each accepted sample goes through a
// bench-side model of the group sum, mean, clamp, two-segment percentage and
// class. Every popped result is compared field by field with the oldest
// predicted one. Calibration and thresholds are rewritten between phases,
// only once the block has drained, and cover inverted ranges, zero-span
// segments, out-of-range mapping, crossed thresholds and unused indexes.
// ----------------------------------------------------------------------------
module water_level_averager_classifier_top_tb;
  import wlac_pkg::*;

  localparam int SAMPLES      = 10;
  localparam int ADC_BITS     = 12;
  localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
  localparam int PHASES       = 12;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [CAL_W-1:0]   mean;
    logic [PCT_W-1:0]   pct;
    logic [CLASS_W-1:0] cls;
  } level_result_t;

  // block inputs start known
  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 push       = 1'b0;
  logic [CAL_W-1:0]     adc_sample = '0;
  logic                 pop        = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  logic                 full;
  logic                 empty;
  logic                 cfg_ready;
  logic [CAL_W-1:0]     mean_reading;
  logic [PCT_W-1:0]     level_percent;
  logic [CLASS_W-1:0]   level_class;

  // bench copy of the block state and calibration
  cal_t                 cal;
  int unsigned          group_sum;
  int                   group_count;

  logic [CAL_W-1:0]     pending_samples[$];
  level_result_t        expected_levels[$];
  level_result_t        want_level;

  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   errors;
  int                   cycle_count;
  int                   phase;

  water_level_averager_classifier_top #(
    .SAMPLES (SAMPLES),
    .ADC_BITS(ADC_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .adc_sample   (adc_sample),
    .empty        (empty),
    .pop          (pop),
    .mean_reading (mean_reading),
    .level_percent(level_percent),
    .level_class  (level_class),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // linear map of x from a..b onto p0..p1, signed division toward zero
  function automatic int seg_interp(int x, int a, int b, int p0, int p1);
    if (b == a) return p0;   // zero-span segment gives its start value
    return (x - a) * (p1 - p0) / (b - a) + p0;
  endfunction

  // fold one accepted sample into the group; a full group yields a result
  function automatic void accumulate_sample(logic [CAL_W-1:0] s);
    int            lvl;
    int            lo;
    int            mid;
    int            hi;
    int            pct;
    int unsigned   avg;
    level_result_t r;
    group_sum   += s & ADC_MAX;
    group_count += 1;
    if (group_count < SAMPLES) return;
    avg         = group_sum / SAMPLES;
    group_sum   = 0;
    group_count = 0;
    lo  = int'(cal.empty_point);
    mid = int'(cal.half_point);
    hi  = int'(cal.full_point);
    lvl = avg;
    // empty point wins when the calibration is inverted
    if (lvl < lo) lvl = lo;
    else if (lvl > hi) lvl = hi;
    if (lvl <= mid) pct = seg_interp(lvl, lo, mid, int'(PCT_ZERO), int'(PCT_HALF));
    else pct = seg_interp(lvl, mid, hi, int'(PCT_HALF), int'(PCT_FULL));
    if (pct < 0) pct = 0;
    if (pct > int'(PCT_FULL)) pct = int'(PCT_FULL);
    r.mean = avg[CAL_W-1:0];
    r.pct  = pct[PCT_W-1:0];
    // low threshold is tested first, so crossed thresholds give low or full, never medium
    if (pct < int'(cal.low_threshold)) r.cls = CLASS_LOW;
    else if (pct < int'(cal.full_threshold)) r.cls = CLASS_MED;
    else r.cls = CLASS_FULL;
    expected_levels.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [CAL_W-1:0] want,
                                      logic [CAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // one group of samples: spread over the range, clustered, flat or extreme
  function automatic void queue_group();
    int style;
    int center;
    int spread;
    int val;
    int k;
    style  = $urandom_range(4);
    center = $urandom_range(ADC_MAX);
    spread = $urandom_range(700);
    for (k = 0; k < SAMPLES; k++) begin
      case (style)
        0: val = $urandom_range(ADC_MAX);
        1: val = center;
        2: val = $urandom_range(1) ? ADC_MAX - $urandom_range(30) : $urandom_range(30);
        default: begin
          val = center + int'($urandom_range(2 * spread)) - spread;
          if (val < 0) val = 0;
          if (val > ADC_MAX) val = ADC_MAX;
        end
      endcase
      pending_samples.push_back(val[CAL_W-1:0]);
    end
  endfunction

  // wait until every sample is in and every result is out, then let the
  // block settle; a partial group stays in the front accumulator
  task automatic wait_for_idle();
    while (pending_samples.size() != 0 || push || expected_levels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // transfer done at this edge, mirror it in the bench calibration
    case (idx)
      REG_EMPTY_POINT:    cal.empty_point    = data[CAL_W-1:0];
      REG_HALF_POINT:     cal.half_point     = data[CAL_W-1:0];
      REG_FULL_POINT:     cal.full_point     = data[CAL_W-1:0];
      REG_LOW_THRESHOLD:  cal.low_threshold  = data[PCT_W-1:0];
      REG_FULL_THRESHOLD: cal.full_threshold = data[PCT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_calibration(int e, int h, int f, int lt, int ft);
    write_reg(REG_EMPTY_POINT, CFG_DAT_W'(e));
    write_reg(REG_HALF_POINT, CFG_DAT_W'(h));
    write_reg(REG_FULL_POINT, CFG_DAT_W'(f));
    write_reg(REG_LOW_THRESHOLD, CFG_DAT_W'(lt));
    write_reg(REG_FULL_THRESHOLD, CFG_DAT_W'(ft));
  endtask

  // random points, ordered half the time; thresholds get raw 12-bit data
  task automatic random_calibration();
    int a;
    int b;
    int c;
    int t;
    int k;
    a = $urandom_range(ADC_MAX);
    b = $urandom_range(ADC_MAX);
    c = $urandom_range(ADC_MAX);
    if ($urandom_range(1)) begin
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    // indexes past the last register must change nothing
    for (k = 1; k <= 3; k++)
      write_reg(CFG_IDX_W'(int'(REG_FULL_THRESHOLD) + k),
                CFG_DAT_W'($urandom_range(ADC_MAX)));
    set_calibration(a, b, c, $urandom_range(ADC_MAX), $urandom_range(ADC_MAX));
  endtask

  // sample driver: next sample after each transfer, hold while full
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) accumulate_sample(adc_sample);
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push       <= 1'b1;
        adc_sample <= pending_samples.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor: check each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: result with none expected, actual mean %0d pct %0d class %0d",
                   $time, mean_reading, level_percent, level_class);
          errors++;
        end else begin
          want_level = expected_levels.pop_front();
          check_field("mean_reading", want_level.mean, mean_reading);
          check_field("level_percent", CAL_W'(want_level.pct), CAL_W'(level_percent));
          check_field("level_class", CAL_W'(want_level.cls), CAL_W'(level_class));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    cal            = '{EMPTY_RST, HALF_RST, FULL_RST, LOW_THR_RST, FULL_THR_RST};
    group_sum      = 0;
    group_count    = 0;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset calibration: top and bottom of the sample range, then a
    // partial group that completes in the first phase
    repeat (SAMPLES) pending_samples.push_back(CAL_W'(ADC_MAX));
    repeat (SAMPLES) pending_samples.push_back('0);
    pending_samples.push_back(12'hAAA);
    pending_samples.push_back(12'h555);
    pending_samples.push_back(12'h800);
    pending_samples.push_back(12'h7FF);
    pending_samples.push_back(12'h001);
    wait_for_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_calibration(500, 1500, 3500, 30, 70);       // ordinary ranges
        1: set_calibration(0, 0, 0, 0, 0);                 // all at zero, lower zero span
        2: set_calibration(ADC_MAX, ADC_MAX, ADC_MAX, 100, 100);
        3: set_calibration(3000, 2000, 1000, 80, 30);      // inverted, crossed thresholds
        4: set_calibration(3000, 1000, 1000, 60, 40);      // upper zero span
        5: set_calibration(3000, 1000, 1500, 10, 90);      // maps above one hundred
        6: set_calibration(2000, 1000, 500, 50, 50);       // maps below zero
        7: set_calibration(1000, 1000, 3000, 0, 100);      // lower zero span, ordered
        default: random_calibration();
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (8 + $urandom_range(2)) queue_group();
      // loose samples leave a partial group for the next phase
      repeat ($urandom_range(SAMPLES - 1))
        pending_samples.push_back(CAL_W'($urandom_range(ADC_MAX)));
      wait_for_idle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* water_level_averager_classifier_top.f */
rtl/wlac_pkg.sv
rtl/wlac_fifo.sv
rtl/wlac_div.sv
rtl/wlac_front.sv
rtl/wlac_back.sv
rtl/water_level_averager_classifier_top.sv
rtl/wlac_checker.sv
bench/water_level_averager_classifier_top_tb.sv
